[src/bhte_pkg.sv]
// shared types, codes and defaults of the bucketed hash table engine
// no dependencies; imported by every module of the block but bhte_ram
package bhte_pkg;

  // default geometry
  localparam int MAX_BUCKETS_LOG2_DEF = 10;
  localparam int SLOTS_PER_BUCKET_DEF = 3;

  // field widths
  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam int LG_W  = 4;

  // request codes on the input channel
  localparam logic [1:0] REQ_GET    = 2'd0;
  localparam logic [1:0] REQ_PUT    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // status codes on the result channel
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // reset value of the bucket count register
  localparam logic [LG_W-1:0] BUCKETS_LOG2_RST = 4'd10;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value_out;
  } out_item_t;

  // decoded operation; the unused request code becomes a no-op
  typedef enum logic [1:0] {
    OP_GET,
    OP_PUT,
    OP_REMOVE,
    OP_NOP
  } op_t;

  // classified request held in the queue between front and back
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } job_t;

  // one slot of a bucket row in memory
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } slot_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

endpackage

[src/bucketed_hash_table_engine.sv]
// Bucketed hash table engine: key-value store of buckets with a few slots each.
// Input channel (in_*) takes get, put and remove requests, one result per request
// leaves on the result channel (out_*). The cfg_* channel writes buckets_log2;
// write it only while the engine is idle. Bucket = key low bits masked by it.
// After reset the bucket memory is cleared, one bucket row per cycle, over all
// 2^MAX_BUCKETS_LOG2 rows; in_ready stays low meanwhile, config writes go on.
// The back end handles one request at a time: one bucket row read, then slot
// compare and write-back; the next row read waits for that write-back, a limit
// set by the read-then-write of a bucket row in the bucket memory.
// On an idle engine a request passes the queue, the row read and the result register.
// A two-entry queue sits between front and back, and the result register lets
// the back end finish one more request while out_ready is low; after that the
// back end holds and the queue fills, then in_ready drops.
// Depends on bhte_pkg, bhte_front, bhte_back, bhte_ram.
module bucketed_hash_table_engine #(
  parameter int MAX_BUCKETS_LOG2 = bhte_pkg::MAX_BUCKETS_LOG2_DEF,
  parameter int SLOTS_PER_BUCKET = bhte_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bhte_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bhte_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bhte_pkg::LG_W-1:0] cfg_data
);
  import bhte_pkg::*;

  localparam int ROW_AW = MAX_BUCKETS_LOG2;
  localparam int ROW_W  = SLOTS_PER_BUCKET * $bits(slot_t);
  localparam int DEPTH  = 1 << MAX_BUCKETS_LOG2;

  logic              q_valid;
  job_t              q_job;
  logic [ROW_AW-1:0] q_row;
  logic              q_pop;
  logic              clearing;
  logic              ram_wr_en;
  logic [ROW_AW-1:0] ram_wr_addr;
  logic [ROW_W-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [ROW_AW-1:0] ram_rd_addr;
  logic [ROW_W-1:0]  ram_rd_data;

  // request decode and queue
  bhte_front #(
    .MAX_BUCKETS_LOG2(MAX_BUCKETS_LOG2)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_row    (q_row),
    .q_pop    (q_pop)
  );

  // bucket execution and results
  bhte_back #(
    .MAX_BUCKETS_LOG2(MAX_BUCKETS_LOG2),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
    .ROW_W           (ROW_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_row      (q_row),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_en  (ram_rd_en),
    .ram_rd_addr(ram_rd_addr),
    .ram_rd_data(ram_rd_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // bucket rows: valid marks, keys and values of all slots
  bhte_ram #(
    .WIDTH(ROW_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

endmodule

[src/bhte_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
module bhte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds its data while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/bhte_front.sv]
// front end: configuration register, request decode, bucket selection, two-entry queue
// depends on bhte_pkg
module bhte_front #(
  parameter int MAX_BUCKETS_LOG2 = bhte_pkg::MAX_BUCKETS_LOG2_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bhte_pkg::in_item_t          in_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bhte_pkg::LG_W-1:0]   cfg_data,
  input  logic                        clearing,
  output logic                        q_valid,
  output bhte_pkg::job_t              q_job,
  output logic [MAX_BUCKETS_LOG2-1:0] q_row,
  input  logic                        q_pop
);
  import bhte_pkg::*;

  localparam int ROW_AW = MAX_BUCKETS_LOG2;

  logic [LG_W-1:0]   buckets_log2_r;
  logic [ROW_AW-1:0] row_mask;
  logic [ROW_AW-1:0] row_in;
  job_t              job_in;
  logic              push;

  job_t              q_job_r [2];
  logic [ROW_AW-1:0] q_row_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;

  // bucket count register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buckets_log2_r <= BUCKETS_LOG2_RST;
    end else if (cfg_valid) begin
      buckets_log2_r <= cfg_data;
    end
  end

  // index mask; counts above the table size saturate at the full index
  always_comb begin
    for (int i = 0; i < ROW_AW; i++) begin
      row_mask[i] = (i < int'(buckets_log2_r));
    end
  end

  assign row_in = in_data.key[ROW_AW-1:0] & row_mask;

  // request decode
  always_comb begin
    job_in.key   = in_data.key;
    job_in.value = in_data.value;
    unique case (in_data.req_type)
      REQ_GET:    job_in.op = OP_GET;
      REQ_PUT:    job_in.op = OP_PUT;
      REQ_REMOVE: job_in.op = OP_REMOVE;
      default:    job_in.op = OP_NOP;
    endcase
  end

  // queue, closed while the memory is being cleared
  assign in_ready = !clearing && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_job_r[wr_ptr_r] <= job_in;
      q_row_r[wr_ptr_r] <= row_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = q_job_r[rd_ptr_r];
  assign q_row   = q_row_r[rd_ptr_r];

endmodule

[src/bhte_back.sv]
// back end: clearing pass, bucket read-modify-write and result register
// depends on bhte_pkg; drives the bucket memory ports
module bhte_back #(
  parameter int MAX_BUCKETS_LOG2 = bhte_pkg::MAX_BUCKETS_LOG2_DEF,
  parameter int SLOTS_PER_BUCKET = bhte_pkg::SLOTS_PER_BUCKET_DEF,
  parameter int ROW_W            = SLOTS_PER_BUCKET * $bits(bhte_pkg::slot_t)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  bhte_pkg::job_t              q_job,
  input  logic [MAX_BUCKETS_LOG2-1:0] q_row,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        ram_wr_en,
  output logic [MAX_BUCKETS_LOG2-1:0] ram_wr_addr,
  output logic [ROW_W-1:0]            ram_wr_data,
  output logic                        ram_rd_en,
  output logic [MAX_BUCKETS_LOG2-1:0] ram_rd_addr,
  input  logic [ROW_W-1:0]            ram_rd_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bhte_pkg::out_item_t         out_data
);
  import bhte_pkg::*;

  localparam int ROW_AW = MAX_BUCKETS_LOG2;
  localparam int SIW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

  bk_state_t state_r, state_nxt;
  logic [ROW_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  slot_t [SLOTS_PER_BUCKET-1:0] row_rd;
  slot_t [SLOTS_PER_BUCKET-1:0] row_wr;
  logic                         hit_any;
  logic [SIW-1:0]               hit_idx;
  logic                         free_any;
  logic [SIW-1:0]               free_idx;
  out_item_t                    res;
  logic                         row_dirty;
  logic                         out_free;

  assign row_rd = ram_rd_data;

  // lowest matching valid slot and lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if (row_rd[s].vld && (row_rd[s].key == q_job.key)) begin
        hit_any = 1'b1;
        hit_idx = SIW'(s);
      end
      if (!row_rd[s].vld) begin
        free_any = 1'b1;
        free_idx = SIW'(s);
      end
    end
  end

  // operation on the bucket row
  always_comb begin
    row_wr        = row_rd;
    row_dirty     = 1'b0;
    res.status    = ST_MISS;
    res.value_out = '0;
    unique case (q_job.op)
      OP_GET: begin
        if (hit_any) begin
          res.status    = ST_DONE;
          res.value_out = row_rd[hit_idx].val;
        end
      end
      OP_PUT: begin
        if (!hit_any) begin
          if (free_any) begin
            row_wr[free_idx].vld = 1'b1;
            row_wr[free_idx].key = q_job.key;
            row_wr[free_idx].val = q_job.value;
            row_dirty            = 1'b1;
            res.status           = ST_DONE;
          end else begin
            res.status = ST_FULL;
          end
        end
      end
      OP_REMOVE: begin
        if (hit_any) begin
          row_wr[hit_idx].vld = 1'b0;
          row_dirty           = 1'b1;
          res.status          = ST_DONE;
          res.value_out       = row_rd[hit_idx].val;
        end
      end
      default: begin
        res.status = ST_MISS;
      end
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // next state, memory control and result loading
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = q_row;
    ram_wr_data   = row_wr;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = q_row;
    unique case (state_r)
      BK_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          ram_rd_en = 1'b1;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (out_free) begin
          ram_wr_en     = row_dirty;
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign clearing  = (state_r == BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/bhte_checker.sv]
`timescale 1ns / 100ps
// monitor and scoreboard for the bucketed hash table engine: predicts every response
// from its own copy of the slot table and compares it with the result channel
// depends on bhte_pkg
module bhte_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  bhte_pkg::in_item_t        in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  bhte_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [bhte_pkg::LG_W-1:0] cfg_data,
  output int                        mismatch_count,
  output int                        results_due
);
  import bhte_pkg::*;

  localparam int MAX_LG    = MAX_BUCKETS_LOG2_DEF;
  localparam int SLOTS     = SLOTS_PER_BUCKET_DEF;
  localparam int NUM_SLOTS = (1 << MAX_LG) * SLOTS;

  // shadow copy of the slot table and the bucket count register
  logic [KEY_W-1:0] shadow_key [NUM_SLOTS];
  logic [VAL_W-1:0] shadow_val [NUM_SLOTS];
  bit               shadow_vld [NUM_SLOTS];
  logic [LG_W-1:0]  shadow_lg;

  out_item_t due_results [$];

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  // look up the request's bucket, update the shadow table, return the response
  function automatic out_item_t table_access(input in_item_t req);
    out_item_t rsp;
    int        lg;
    int        base;
    int        hit;
    int        free_slot;
    int        s;
    lg        = (shadow_lg > MAX_LG) ? MAX_LG : int'(shadow_lg);
    base      = int'(req.key & ((64'd1 << lg) - 64'd1)) * SLOTS;
    hit       = -1;
    free_slot = -1;
    for (s = 0; s < SLOTS; s++) begin
      if (hit < 0 && shadow_vld[base + s] && shadow_key[base + s] == req.key)
        hit = base + s;
      if (free_slot < 0 && !shadow_vld[base + s])
        free_slot = base + s;
    end
    rsp.status    = ST_MISS;
    rsp.value_out = '0;
    case (req.req_type)
      REQ_GET: begin
        if (hit >= 0) begin
          rsp.status    = ST_DONE;
          rsp.value_out = shadow_val[hit];
        end
      end
      REQ_PUT: begin
        // a present key is refused; otherwise the lowest free slot takes it
        if (hit < 0) begin
          if (free_slot >= 0) begin
            shadow_key[free_slot] = req.key;
            shadow_val[free_slot] = req.value;
            shadow_vld[free_slot] = 1'b1;
            rsp.status            = ST_DONE;
          end else begin
            rsp.status = ST_FULL;
          end
        end
      end
      REQ_REMOVE: begin
        if (hit >= 0) begin
          rsp.status      = ST_DONE;
          rsp.value_out   = shadow_val[hit];
          shadow_vld[hit] = 1'b0;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // watch all three channels; compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (shadow_vld[i]) shadow_vld[i] = 1'b0;
      shadow_lg = BUCKETS_LOG2_RST;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        shadow_lg = cfg_data;
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no request outstanding: status %0d value_out %h",
                 out_data.status, out_data.value_out);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.value_out !== want.value_out) begin
            $error("value_out: expected %h, actual %h", want.value_out, out_data.value_out);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        due_results.push_back(table_access(in_data));
    end
    results_due <= due_results.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// top of the bucketed hash table engine testbench: clock, reset, request and
// config stimulus, result-side backpressure and the verdict
// depends on bhte_pkg, bucketed_hash_table_engine and bhte_checker
module tb_top;
  import bhte_pkg::*;

  localparam int  LONG_HOLD = 400;
  localparam int  POOL_SIZE = 12;
  localparam real LIMIT_NS  = 600000.0;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LG_W-1:0]     cfg_data  = '0;

  logic                quiet     = 1'b0;
  logic                hold_req  = 1'b0;
  int                  mismatch_count;
  int                  results_due;
  logic [KEY_W-1:0]    key_pool [POOL_SIZE];

  always #1 clk = ~clk;

  bucketed_hash_table_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bhte_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // hard stop in case the engine hangs
  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  // result-side backpressure: random stall bursts, one long hold on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // offer one request and hold it until the transfer
  task automatic send_req(input logic [1:0] rt, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v);
    in_valid         <= 1'b1;
    in_data.req_type <= rt;
    in_data.key      <= k;
    in_data.value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // random gap on the request side
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // wait for every response, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_buckets_log2(input logic [LG_W-1:0] lg);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= lg;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random traffic over a small key pool so buckets collide and fill up
  task automatic run_phase(input logic [LG_W-1:0] lg, input int count, input bit press);
    logic [9:0]       hint [3];
    logic [KEY_W-1:0] k;
    logic [1:0]       rt;
    int               r;
    write_buckets_log2(lg);
    foreach (hint[i]) hint[i] = 10'($urandom);
    foreach (key_pool[i]) begin
      key_pool[i]      = {$urandom, $urandom};
      key_pool[i][9:0] = hint[$urandom_range(0, 2)];
    end
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35)      rt = REQ_GET;
      else if (r < 70) rt = REQ_PUT;
      else if (r < 95) rt = REQ_REMOVE;
      else             rt = 2'(~0);
      if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
      else                           k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (press && n == count / 3)
        hold_req <= 1'b1;
      send_req(rt, k, {$urandom, $urandom});
      sender_gap();
    end
  endtask

  initial begin
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    logic [1:0]       unused_code;
    ka          = 64'h8000_0000_0000_0001;
    kb          = 64'h5555_aaaa_5555_aaa2;
    unused_code = 2'(~0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full bucket count, zero and all-ones keys and values
    send_req(REQ_GET, '0, '1);
    send_req(REQ_PUT, '0, '0);
    send_req(REQ_GET, '0, '1);
    send_req(REQ_PUT, '0, '1);
    send_req(REQ_PUT, '1, '1);
    sender_gap();
    send_req(REQ_GET, '1, '0);
    send_req(REQ_REMOVE, '1, '0);
    send_req(REQ_REMOVE, '1, '0);
    send_req(unused_code, '0, '1);
    send_req(REQ_GET, '0, '0);

    // directed: one bucket only, fill it and overflow
    write_buckets_log2('0);
    send_req(REQ_PUT, ka, 64'h0123_4567_89ab_cdef);
    send_req(REQ_PUT, kb, 64'hfedc_ba98_7654_3210);
    send_req(REQ_PUT, 64'd3, 64'h1);
    send_req(REQ_REMOVE, '0, '1);
    send_req(REQ_PUT, 64'd3, 64'h2);
    send_req(REQ_GET, kb, '0);

    // directed: oversized count clamps; old entries sit in other buckets now
    write_buckets_log2('1);
    send_req(REQ_GET, kb, '0);
    send_req(REQ_PUT, ka, 64'h77);
    send_req(REQ_GET, ka, '0);

    // random phases over several bucket counts, the last one without idling
    run_phase(4'd0, 150, 1'b0);
    run_phase(4'd1, 150, 1'b1);
    run_phase(4'd2, 170, 1'b0);
    run_phase(4'd10, 280, 1'b0);
    run_phase(4'(~0), 150, 1'b0);
    run_phase(4'($urandom_range(3, 9)), 200, 1'b0);
    quiet <= 1'b1;
    run_phase(4'd3, 280, 1'b0);

    drain();
    if (mismatch_count == 0 && results_due == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
